// ----- rtl/rap_pkg.sv -----
package rap_pkg;

  localparam int VALUE_W    = 63;
  localparam int RADIX_W    = 6;
  localparam int LIMIT_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // divider: 64-bit padded dividend, eight quotient bits per cycle
  localparam int DIV_W      = 64;
  localparam int DIV_BITS   = 8;
  localparam int DIV_ROUNDS = DIV_W / DIV_BITS;
  localparam int RND_W      = $clog2(DIV_ROUNDS);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

  typedef enum logic [STATUS_W-1:0] {
    STATUS_FOUND    = 2'd0,
    STATUS_LIMIT    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX = 2'd0,
    REG_LIMIT = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIGIT,
    S_DIVIDE,
    S_ACCUM,
    S_DECIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [RADIX_W-1:0] base;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic [LIMIT_W-1:0] steps;
    logic [VALUE_W-1:0] value;
  } res_t;

endpackage

// ----- rtl/rap_if.sv -----
interface rap_req_if;
  logic                        valid;
  logic                        ready;
  logic [rap_pkg::VALUE_W-1:0] start_value;

  modport source (output valid, output start_value, input ready);
  modport sink (input valid, input start_value, output ready);
endinterface

interface rap_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rap_pkg::STATUS_W-1:0] status;
  logic [rap_pkg::LIMIT_W-1:0]  steps_taken;
  logic [rap_pkg::VALUE_W-1:0]  palindrome_value;

  modport source (output valid, output status, output steps_taken, output palindrome_value,
                  input ready);
  modport sink (input valid, input status, input steps_taken, input palindrome_value,
                output ready);
endinterface

interface rap_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rap_pkg::CFG_IDX_W-1:0]  index;
  logic [rap_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/reverse_add_palindrome_search.sv -----
// Reverse-and-add palindrome search. A request carries a start value; the block writes it
// in the configured radix (clamped to 2..36) and, until the digits read the same both ways
// or iteration_limit additions are made, adds the digit-reversed value to it. One response
// per request: status (found, limit reached, overflow past 2^63-1 or more than MAX_DIGITS
// digits), additions made, and the palindrome when found. One request is worked at a time.
// Digits come from a single shared divider giving eight quotient bits a cycle. A new request is
// taken while the previous response still waits in the output register. Configuration
// writes are taken only while no request is in progress.
module reverse_add_palindrome_search #(
  parameter int MAX_DIGITS = 64
) (
  input logic      clk,
  input logic      rst,
  rap_cfg_if.sink  cfg,
  rap_req_if.sink  req,
  rap_rsp_if.source rsp
);

  logic [rap_pkg::RADIX_W-1:0] radix;
  logic [rap_pkg::LIMIT_W-1:0] iteration_limit;
  rap_pkg::cfg_t               core_cfg;
  logic                        core_req_ready;
  logic                        core_res_valid;
  logic                        core_res_ready;
  rap_pkg::res_t               core_res;
  logic                        out_valid;
  rap_pkg::res_t               out_res;

  always_comb begin
    if (radix < rap_pkg::RADIX_MIN) begin
      core_cfg.base = rap_pkg::RADIX_MIN;
    end else if (radix > rap_pkg::RADIX_MAX) begin
      core_cfg.base = rap_pkg::RADIX_MAX;
    end else begin
      core_cfg.base = radix;
    end
    core_cfg.limit = iteration_limit;
  end

  assign cfg.ready = core_req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix           <= rap_pkg::RADIX_RESET;
      iteration_limit <= rap_pkg::LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (rap_pkg::cfg_reg_t'(cfg.index))
        rap_pkg::REG_RADIX: radix           <= cfg.data[rap_pkg::RADIX_W-1:0];
        rap_pkg::REG_LIMIT: iteration_limit <= cfg.data[rap_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  rap_core #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (core_cfg),
    .req_valid   (req.valid),
    .req_ready   (core_req_ready),
    .start_value (req.start_value),
    .res_valid   (core_res_valid),
    .res_ready   (core_res_ready),
    .res         (core_res)
  );

  assign req.ready      = core_req_ready;
  assign core_res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_res_valid && core_res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_valid && core_res_ready) begin
      out_res <= core_res;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_res.status;
  assign rsp.steps_taken      = out_res.steps;
  assign rsp.palindrome_value = out_res.value;

endmodule

// ----- rtl/rap_div.sv -----
module rap_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rap_pkg::VALUE_W-1:0]  dividend,
  input  logic [rap_pkg::RADIX_W-1:0]  divisor,
  output logic                         busy,
  output logic                         done,
  output logic [rap_pkg::VALUE_W-1:0]  quotient,
  output logic [rap_pkg::RADIX_W-1:0]  remainder
);

  logic [rap_pkg::DIV_W-1:0]   acc;
  logic [rap_pkg::DIV_W-1:0]   acc_next;
  logic [rap_pkg::RADIX_W-1:0] rem;
  logic [rap_pkg::RADIX_W-1:0] rem_next;
  logic [rap_pkg::RADIX_W-1:0] dvs;
  logic [rap_pkg::RND_W-1:0]   rnd;

  // restoring division, MSB first; quotient bits shift in at the bottom
  always_comb begin
    logic [rap_pkg::RADIX_W:0]   r7;
    logic                        ge;
    logic [rap_pkg::DIV_W-1:0]   a;
    logic [rap_pkg::RADIX_W-1:0] r;
    a = acc;
    r = rem;
    for (int i = 0; i < rap_pkg::DIV_BITS; i++) begin
      r7 = {r, a[rap_pkg::DIV_W-1]};
      ge = (r7 >= {1'b0, dvs});
      a  = {a[rap_pkg::DIV_W-2:0], ge};
      r  = ge ? rap_pkg::RADIX_W'(r7 - {1'b0, dvs}) : r7[rap_pkg::RADIX_W-1:0];
    end
    acc_next = a;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 1'b1;
        if (rnd == rap_pkg::RND_W'(rap_pkg::DIV_ROUNDS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= {1'b0, dividend};
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quotient  = acc[rap_pkg::VALUE_W-1:0];
  assign remainder = rem;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (busy && dvs != '0) |-> (rem < dvs))
    else $error("division remainder not below divisor");

endmodule

// ----- rtl/rap_core.sv -----
module rap_core #(
  parameter int MAX_DIGITS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rap_pkg::cfg_t               cfg,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [rap_pkg::VALUE_W-1:0] start_value,
  output logic                        res_valid,
  input  logic                        res_ready,
  output rap_pkg::res_t               res
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int PW    = rap_pkg::VALUE_W + rap_pkg::RADIX_W;

  rap_pkg::state_t state, state_next;

  logic [rap_pkg::VALUE_W-1:0] wv, wv_next;
  logic [rap_pkg::VALUE_W-1:0] v, v_next;
  logic [rap_pkg::VALUE_W-1:0] rev, rev_next;
  logic [PW-1:0]               rev_prod, rev_prod_next;
  logic                        rev_ovf, rev_ovf_next;
  logic                        cap_fail, cap_fail_next;
  logic [CNT_W-1:0]            cnt, cnt_next;
  logic [rap_pkg::LIMIT_W-1:0] steps, steps_next;
  rap_pkg::res_t               res_q, res_next;

  logic                        div_start;
  logic                        div_busy;
  logic                        div_done;
  logic [rap_pkg::VALUE_W-1:0] div_quot;
  logic [rap_pkg::RADIX_W-1:0] div_rem;

  logic [PW-1:0]               acc_sum;
  logic [rap_pkg::VALUE_W:0]   add_sum;

  rap_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (v),
    .divisor   (cfg.base),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign acc_sum = rev_prod + PW'(div_rem);
  assign add_sum = {1'b0, wv} + {1'b0, rev};

  always_comb begin
    state_next    = state;
    wv_next       = wv;
    v_next        = v;
    rev_next      = rev;
    rev_prod_next = rev_prod;
    rev_ovf_next  = rev_ovf;
    cap_fail_next = cap_fail;
    cnt_next      = cnt;
    steps_next    = steps;
    res_next      = res_q;
    div_start     = 1'b0;
    req_ready     = (state == rap_pkg::S_IDLE);
    res_valid     = (state == rap_pkg::S_DONE);

    case (state)
      rap_pkg::S_IDLE: begin
        if (req_valid) begin
          wv_next       = start_value;
          v_next        = start_value;
          rev_next      = '0;
          rev_ovf_next  = 1'b0;
          cap_fail_next = 1'b0;
          cnt_next      = '0;
          steps_next    = '0;
          state_next    = rap_pkg::S_DIGIT;
        end
      end
      rap_pkg::S_DIGIT: begin
        if (v == '0) begin
          state_next = rap_pkg::S_DECIDE;
        end else if (cnt == CNT_W'(MAX_DIGITS)) begin
          cap_fail_next = 1'b1;
          state_next    = rap_pkg::S_DECIDE;
        end else begin
          div_start     = 1'b1;
          rev_prod_next = PW'(rev) * PW'(cfg.base);
          state_next    = rap_pkg::S_DIVIDE;
        end
      end
      rap_pkg::S_DIVIDE: begin
        if (div_done) begin
          v_next     = div_quot;
          state_next = rap_pkg::S_ACCUM;
        end
      end
      rap_pkg::S_ACCUM: begin
        // digits arrive least significant first: that is the reversed order
        if (!rev_ovf) begin
          if (acc_sum[PW-1:rap_pkg::VALUE_W] != '0) begin
            rev_ovf_next = 1'b1;
          end else begin
            rev_next = acc_sum[rap_pkg::VALUE_W-1:0];
          end
        end
        cnt_next   = cnt + 1'b1;
        state_next = rap_pkg::S_DIGIT;
      end
      rap_pkg::S_DECIDE: begin
        state_next     = rap_pkg::S_DONE;
        res_next.steps = steps;
        res_next.value = '0;
        if (cap_fail) begin
          res_next.status = rap_pkg::STATUS_OVERFLOW;
        end else if (!rev_ovf && rev == wv) begin
          res_next.status = rap_pkg::STATUS_FOUND;
          res_next.value  = wv;
        end else if (steps == cfg.limit) begin
          res_next.status = rap_pkg::STATUS_LIMIT;
        end else if (rev_ovf || add_sum[rap_pkg::VALUE_W]) begin
          res_next.status = rap_pkg::STATUS_OVERFLOW;
        end else begin
          wv_next      = add_sum[rap_pkg::VALUE_W-1:0];
          v_next       = add_sum[rap_pkg::VALUE_W-1:0];
          rev_next     = '0;
          rev_ovf_next = 1'b0;
          cnt_next     = '0;
          steps_next   = steps + 1'b1;
          state_next   = rap_pkg::S_DIGIT;
        end
      end
      rap_pkg::S_DONE: begin
        if (res_ready) begin
          state_next = rap_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rap_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rap_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    wv       <= wv_next;
    v        <= v_next;
    rev      <= rev_next;
    rev_prod <= rev_prod_next;
    rev_ovf  <= rev_ovf_next;
    cap_fail <= cap_fail_next;
    cnt      <= cnt_next;
    steps    <= steps_next;
    res_q    <= res_next;
  end

  assign res = res_q;

  a_steps_within_limit: assert property (@(posedge clk) disable iff (rst)
    (state != rap_pkg::S_IDLE) |-> (steps <= cfg.limit))
    else $error("step count beyond iteration limit");

  a_digits_within_capacity: assert property (@(posedge clk) disable iff (rst)
    (state != rap_pkg::S_IDLE) |-> (cnt <= CNT_W'(MAX_DIGITS)))
    else $error("digit count beyond capacity");

  a_divider_active: assert property (@(posedge clk) disable iff (rst)
    (state == rap_pkg::S_DIVIDE) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

  a_value_only_when_found: assert property (@(posedge clk) disable iff (rst)
    (state == rap_pkg::S_DONE && res_q.status != rap_pkg::STATUS_FOUND) |-> (res_q.value == '0))
    else $error("value reported without a palindrome");

endmodule
